// ----- hdl/assert_macros.svh -----
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, idle in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, idle in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ----- hdl/vcr_pkg.sv -----
package vcr_pkg;

  // cordic steps and fixed-point constants, angles in q.24, trig in q2.30
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 34;   // cordic x/y width
  localparam int ZW           = 29;   // cordic angle width
  localparam int AW           = 16;   // input angle width
  localparam int WW           = 15;   // window width
  localparam int OW           = 24;   // coordinate width
  localparam int HW           = 24;   // half-extent width (q.16, nonnegative)

  localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [ZW-1:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [ZW-1:0] TWO_PI_Q24  = 29'sd105414358;
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 29'sd26353589;

  // arctangent table, q.24
  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] t;
    unique case (i)
      0: t = 29'sd13176795;
      1: t = 29'sd7778716;
      2: t = 29'sd4110060;
      3: t = 29'sd2086331;
      4: t = 29'sd1047214;
      5: t = 29'sd524117;
      6: t = 29'sd262123;
      7: t = 29'sd131069;
      default: t = ZW'(32'sd1 <<< (24 - i));
    endcase
    return t;
  endfunction

  // one cordic lane
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } lane_t;

  // four angle lanes: window h, window v, tilt, pan
  localparam int LANES = 4;
  typedef lane_t [LANES-1:0] lanes_t;

  // reduce an angle in q.24 into [-pi/2, pi/2] and seed the lane
  function automatic lane_t seed_lane(input logic signed [ZW-1:0] a);
    lane_t l;
    logic signed [ZW-1:0] z;
    z = a;
    if (z > PI_Q24) z = z - TWO_PI_Q24;
    else if (z < -PI_Q24) z = z + TWO_PI_Q24;
    l.neg = 1'b0;
    if (z > HALF_PI_Q24) begin
      z = z - PI_Q24;
      l.neg = 1'b1;
    end else if (z < -HALF_PI_Q24) begin
      z = z + PI_Q24;
      l.neg = 1'b1;
    end
    l.x = CORDIC_K;
    l.y = '0;
    l.z = z;
    return l;
  endfunction

endpackage

// ----- hdl/vcr_if.sv -----
interface vcr_in_if;
  logic                 valid;
  logic                 ready;
  logic [14:0]          window_horizontal;
  logic [14:0]          window_vertical;
  logic signed [15:0]   tilt_angle;
  logic signed [15:0]   pan_angle;
  modport source (output valid, window_horizontal, window_vertical, tilt_angle, pan_angle,
                  input ready);
  modport sink   (input valid, window_horizontal, window_vertical, tilt_angle, pan_angle,
                  output ready);
endinterface

interface vcr_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic signed [23:0] origin_z;
  logic signed [23:0] left_top_x;
  logic signed [23:0] left_top_y;
  logic signed [23:0] left_top_z;
  logic signed [23:0] right_bottom_x;
  logic signed [23:0] right_bottom_y;
  logic signed [23:0] right_bottom_z;
  modport source (output valid, origin_x, origin_y, origin_z, left_top_x, left_top_y,
                  left_top_z, right_bottom_x, right_bottom_y, right_bottom_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, left_top_x, left_top_y,
                  left_top_z, right_bottom_x, right_bottom_y, right_bottom_z,
                  output ready);
endinterface

// ----- hdl/vcr_cordic_cell.sv -----
module vcr_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  vcr_pkg::lanes_t lanes_i,
  output vcr_pkg::lanes_t lanes_o
);
  import vcr_pkg::*;

  lanes_t lanes_nxt, lanes_r;

  // one micro-rotation on every lane
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lanes_nxt[k].neg = lanes_i[k].neg;
      if (lanes_i[k].z >= 0) begin
        lanes_nxt[k].x = lanes_i[k].x - (lanes_i[k].y >>> STEP);
        lanes_nxt[k].y = lanes_i[k].y + (lanes_i[k].x >>> STEP);
        lanes_nxt[k].z = lanes_i[k].z - atan_q24(STEP);
      end else begin
        lanes_nxt[k].x = lanes_i[k].x + (lanes_i[k].y >>> STEP);
        lanes_nxt[k].y = lanes_i[k].y - (lanes_i[k].x >>> STEP);
        lanes_nxt[k].z = lanes_i[k].z + atan_q24(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) lanes_r <= lanes_nxt;
  end

  assign lanes_o = lanes_r;
endmodule

// ----- hdl/vcr_divider.sv -----
module vcr_divider (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [vcr_pkg::CW-1:0] s_i,
  input  logic signed [vcr_pkg::CW-1:0] c_i,
  output logic [vcr_pkg::HW-1:0]      q_o
);
  import vcr_pkg::*;

  // pipelined restoring divider: one quotient bit per stage, saturating at 2^23-1
  localparam int NW   = 52;           // numerator width, nonneg
  localparam int QB   = HW + 1;        // quotient bits kept (extra for saturation)
  localparam int DW   = CW;

  logic [NW-1:0]    num_r  [QB+1];
  logic [DW-1:0]    den_r  [QB+1];
  logic [DW:0]      rem_r  [QB+1];
  logic [QB-1:0]    quo_r  [QB+1];
  logic             sat_r  [QB+1];
  logic             zero_r [QB+1];

  logic signed [NW:0] n_full;
  logic               c_pos;
  logic [NW:0]        hi_part;

  // numerator s*65536 + c/2 with c > 0 truncating division
  always_comb begin
    c_pos   = (c_i > 0);
    n_full  = (53'(s_i) <<< 16) + 53'(c_i >>> 1);
    hi_part = n_full >> QB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= n_full[NW-1:0];
      den_r[0]  <= c_i;
      quo_r[0]  <= '0;
      zero_r[0] <= c_pos && (n_full < 0);
      // quotient overflows if n >> QB >= c
      sat_r[0]  <= !c_pos || (!(n_full < 0) && (hi_part >= (NW+1)'(c_i)));
      rem_r[0]  <= '0;
    end
  end

  // with no overflow, remainder of top bits < c; start from n >> QB
  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [DW:0] trial;
    logic [DW:0] rem_in;
    always_comb begin
      rem_in = (g == 0) ? (DW+1)'(num_r[0] >> QB) : rem_r[g];
      trial  = {rem_in[DW-1:0], num_r[g][QB-1-g]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[g+1]  <= num_r[g];
        den_r[g+1]  <= den_r[g];
        sat_r[g+1]  <= sat_r[g];
        zero_r[g+1] <= zero_r[g];
        if (trial >= {1'b0, den_r[g]}) begin
          rem_r[g+1] <= trial - {1'b0, den_r[g]};
          quo_r[g+1] <= {quo_r[g][QB-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= trial;
          quo_r[g+1] <= {quo_r[g][QB-2:0], 1'b0};
        end
      end
    end
  end

  localparam logic [HW-1:0] HMAX = {HW{1'b1}} >> 1;

  always_comb begin
    if (zero_r[QB]) q_o = '0;
    else if (sat_r[QB] || quo_r[QB] > QB'(HMAX)) q_o = HMAX;
    else q_o = quo_r[QB][HW-1:0];
  end
endmodule

// ----- hdl/vcr_rotator.sv -----
module vcr_rotator (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [vcr_pkg::CW-1:0] st_i,
  input  logic signed [vcr_pkg::CW-1:0] ct_i,
  input  logic signed [vcr_pkg::CW-1:0] sp_i,
  input  logic signed [vcr_pkg::CW-1:0] cp_i,
  input  logic [vcr_pkg::HW-1:0]        x_i,
  input  logic [vcr_pkg::HW-1:0]        y_i,
  output logic signed [vcr_pkg::OW-1:0] res_o [9]
);
  import vcr_pkg::*;

  // matrix entries q2.30, products taken with a register after each
  localparam int PW = 2 * CW;
  logic signed [PW-1:0] p01_r, p02_r, p21_r, p22_r;
  logic signed [CW-1:0] st1_r, ct1_r, sp1_r, cp1_r;
  logic [HW-1:0]        x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p01_r <= sp_i * st_i;
      p02_r <= sp_i * ct_i;
      p21_r <= cp_i * st_i;
      p22_r <= cp_i * ct_i;
      st1_r <= st_i; ct1_r <= ct_i; sp1_r <= sp_i; cp1_r <= cp_i;
      x1_r <= x_i; y1_r <= y_i;
    end
  end

  // rounded entries
  logic signed [CW-1:0] r00_r, r01_r, r02_r, r11_r, r12_r, r20_r, r21_r, r22_r;
  logic [HW-1:0]        x2_r, y2_r;
  localparam logic signed [PW-1:0] RND = PW'(64'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (en) begin
      r00_r <= cp1_r;
      r01_r <= CW'((p01_r + RND) >>> 30);
      r02_r <= CW'((p02_r + RND) >>> 30);
      r11_r <= ct1_r;
      r12_r <= -st1_r;
      r20_r <= -sp1_r;
      r21_r <= CW'((p21_r + RND) >>> 30);
      r22_r <= CW'((p22_r + RND) >>> 30);
      x2_r <= x1_r;
      y2_r <= y1_r;
    end
  end

  // entry times coordinate (coordinate < 2^24, so vh is zero): floor(e*v / 2^24), q.22
  localparam int TW = CW + HW + 1;
  logic signed [TW-1:0] tx0_r, tx2_r, ty0_r, ty1_r, ty2_r;
  logic signed [CW-1:0] z0_r, z1_r, z2_r;
  logic signed [CW-1:0] ex0, ex2;

  assign ex0 = r00_r;
  assign ex2 = r20_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tx0_r <= ex0 * $signed({1'b0, x2_r});
      tx2_r <= ex2 * $signed({1'b0, x2_r});
      ty0_r <= r01_r * $signed({1'b0, y2_r});
      ty1_r <= r11_r * $signed({1'b0, y2_r});
      ty2_r <= r21_r * $signed({1'b0, y2_r});
      z0_r  <= r02_r;
      z1_r  <= r12_r;
      z2_r  <= r22_r;
    end
  end

  // terms: a*2^24 floor shift; z term is e*65536 >> 24 = e >>> 8
  localparam int SW = TW;
  logic signed [SW-1:0] ax0, ax2, ay0, ay1, ay2, az0, az1, az2, nx0, nx2, ny0, ny1, ny2;

  always_comb begin
    ax0 = tx0_r >>> 24; ax2 = tx2_r >>> 24;
    ay0 = ty0_r >>> 24; ay1 = ty1_r >>> 24; ay2 = ty2_r >>> 24;
    // floor of a negated product
    nx0 = (-tx0_r) >>> 24; nx2 = (-tx2_r) >>> 24;
    ny0 = (-ty0_r) >>> 24; ny1 = (-ty1_r) >>> 24; ny2 = (-ty2_r) >>> 24;
    az0 = SW'(z0_r >>> 8); az1 = SW'(z1_r >>> 8); az2 = SW'(z2_r >>> 8);
  end

  logic signed [SW+1:0] sum_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      // origin (-x,-y,1)
      sum_r[0] <= (SW+2)'(nx0) + (SW+2)'(ny0) + (SW+2)'(az0);
      sum_r[1] <= (SW+2)'(ny1) + (SW+2)'(az1);
      sum_r[2] <= (SW+2)'(nx2) + (SW+2)'(ny2) + (SW+2)'(az2);
      // left-top (-x,+y,1)
      sum_r[3] <= (SW+2)'(nx0) + (SW+2)'(ay0) + (SW+2)'(az0);
      sum_r[4] <= (SW+2)'(ay1) + (SW+2)'(az1);
      sum_r[5] <= (SW+2)'(nx2) + (SW+2)'(ay2) + (SW+2)'(az2);
      // right-bottom (+x,-y,1)
      sum_r[6] <= (SW+2)'(ax0) + (SW+2)'(ny0) + (SW+2)'(az0);
      sum_r[7] <= (SW+2)'(ny1) + (SW+2)'(az1);
      sum_r[8] <= (SW+2)'(ax2) + (SW+2)'(ny2) + (SW+2)'(az2);
    end
  end

  localparam logic signed [SW+1:0] OMAX = (SW+2)'((64'sd1 <<< (OW-1)) - 1);
  localparam logic signed [SW+1:0] OMIN = -OMAX - 1;

  // round to q.16 and saturate
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic signed [SW+1:0] r;
      r = (sum_r[k] + 32) >>> 6;
      if (r > OMAX) res_o[k] = OMAX[OW-1:0];
      else if (r < OMIN) res_o[k] = OMIN[OW-1:0];
      else res_o[k] = r[OW-1:0];
    end
  end
endmodule

// ----- hdl/viewport_corner_rotation_core.sv -----
// channel  | dir | payload
// in_      | in  | window_horizontal, window_vertical, tilt_angle, pan_angle
// out_     | out | nine rotated corner coordinates, q7.16
//
// one item per cycle while the output is not stalled; stages: seed register, 24 cordic
// cells, sign register, 26 divider stages, 4 rotator stages, output register;
// the whole pipeline advances only when the output register is free or being drained
// rst_n clears the valid bits of every stage; payload registers are not reset
module viewport_corner_rotation_core (
  input  logic      clk,
  input  logic      rst_n,
  vcr_in_if.sink    in_ch,
  vcr_out_if.source out_ch
);
  import vcr_pkg::*;

  localparam int LAT = 1 + CORDIC_STEPS + 1 + (HW + 2) + 4;

  logic              en;
  logic [LAT-1:0]    vld_r;
  logic              out_valid_r;

  // stall everything when the output register holds an untaken result
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_ch.valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end
  assign out_ch.valid = out_valid_r;

  // angle seeding into q.24 and range folding
  lanes_t seed_r;
  always_ff @(posedge clk) begin
    if (en) begin
      seed_r[0] <= seed_lane(ZW'({1'b0, in_ch.window_horizontal}) <<< 10);
      seed_r[1] <= seed_lane(ZW'({1'b0, in_ch.window_vertical}) <<< 10);
      seed_r[2] <= seed_lane(ZW'(in_ch.tilt_angle) <<< 11);
      seed_r[3] <= seed_lane(ZW'(in_ch.pan_angle) <<< 11);
    end
  end

  // cordic chain
  lanes_t chain [CORDIC_STEPS+1];
  assign chain[0] = seed_r;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    vcr_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en), .lanes_i(chain[i]), .lanes_o(chain[i+1])
    );
  end

  // apply fold sign
  logic signed [CW-1:0] sn_r [LANES];
  logic signed [CW-1:0] cs_r [LANES];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        sn_r[k] <= chain[CORDIC_STEPS][k].neg ? -chain[CORDIC_STEPS][k].y
                                              :  chain[CORDIC_STEPS][k].y;
        cs_r[k] <= chain[CORDIC_STEPS][k].neg ? -chain[CORDIC_STEPS][k].x
                                              :  chain[CORDIC_STEPS][k].x;
      end
    end
  end

  // half-extents
  logic [HW-1:0] hx, hy;
  vcr_divider u_div_x (.clk(clk), .en(en), .s_i(sn_r[0]), .c_i(cs_r[0]), .q_o(hx));
  vcr_divider u_div_y (.clk(clk), .en(en), .s_i(sn_r[1]), .c_i(cs_r[1]), .q_o(hy));

  // delay tilt/pan trig alongside the divider
  localparam int DD = HW + 2;
  logic signed [CW-1:0] trig_d [DD][4];
  always_ff @(posedge clk) begin
    if (en) begin
      trig_d[0][0] <= sn_r[2]; trig_d[0][1] <= cs_r[2];
      trig_d[0][2] <= sn_r[3]; trig_d[0][3] <= cs_r[3];
      for (int d = 1; d < DD; d++) trig_d[d] <= trig_d[d-1];
    end
  end

  logic signed [OW-1:0] res [9];
  vcr_rotator u_rot (
    .clk(clk), .en(en),
    .st_i(trig_d[DD-1][0]), .ct_i(trig_d[DD-1][1]),
    .sp_i(trig_d[DD-1][2]), .cp_i(trig_d[DD-1][3]),
    .x_i(hx), .y_i(hy), .res_o(res)
  );

  // output register
  logic signed [OW-1:0] res_r [9];
  always_ff @(posedge clk) begin
    if (en) res_r <= res;
  end

  assign out_ch.origin_x       = res_r[0];
  assign out_ch.origin_y       = res_r[1];
  assign out_ch.origin_z       = res_r[2];
  assign out_ch.left_top_x     = res_r[3];
  assign out_ch.left_top_y     = res_r[4];
  assign out_ch.left_top_z     = res_r[5];
  assign out_ch.right_bottom_x = res_r[6];
  assign out_ch.right_bottom_y = res_r[7];
  assign out_ch.right_bottom_z = res_r[8];
endmodule

// ----- hdl/vcr_checker.sv -----
`include "assert_macros.svh"

module vcr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [23:0] out_origin_y,
  input logic signed [23:0] out_right_bottom_y
);
  // output valid held while stalled
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // input side is free whenever the output side is free
  `ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
  // stall propagates back to the input
  `ASSERT_IMPL(a_stall_back, clk, rst_n, out_valid && !out_ready, !in_ready)
  // origin and right-bottom share their y row
  `ASSERT_IMPL(a_y_shared, clk, rst_n, out_valid, out_origin_y == out_right_bottom_y)
endmodule

bind viewport_corner_rotation_core vcr_checker u_vcr_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_origin_y(out_ch.origin_y), .out_right_bottom_y(out_ch.right_bottom_y)
);

// ----- verif/viewport_corner_rotation_core_tb.sv -----
module viewport_corner_rotation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcr_pkg::*;

  localparam int  HALF_PERIOD = 6;
  localparam int  RANDOM_ITEMS = 1930;
  localparam int  DRAIN_CYCLES = 120;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam longint Q24_TWO_PI = 64'sd105414358;
  localparam longint Q24_PI = 64'sd52707179;
  localparam longint Q24_HALF_PI = 64'sd26353589;
  localparam longint Q30_GAIN = 64'sd652032874;

  typedef struct {
    logic [WW-1:0]        win_h;
    logic [WW-1:0]        win_v;
    logic signed [AW-1:0] tilt;
    logic signed [AW-1:0] pan;
  } view_t;

  typedef struct {
    logic signed [OW-1:0] c [9];
  } corners_t;

  // directed row: angles plus an optional hand-known origin z
  typedef struct {
    view_t                v;
    bit                   z_known;
    logic signed [OW-1:0] z_value;
  } view_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches = 0;
  bit   in_done = 1'b0;
  bit   out_fired = 1'b0;
  bit   burst = 1'b0;
  int   ready_hold = 0;
  corners_t pending_corners [$];

  vcr_in_if  in_ch ();
  vcr_out_if out_ch ();

  viewport_corner_rotation_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // run limit
  initial begin
    #5ms;
    $display("viewport_corner_rotation_core verification failed");
    $finish;
  end

  // cordic sine and cosine, angle in q.24, results in q2.30
  function automatic void cordic_sin_cos(input longint ang, output longint s,
                                         output longint c);
    longint x, y, z, nx;
    bit     flip;
    x = Q30_GAIN;
    y = 0;
    flip = 1'b0;
    z = ang % Q24_TWO_PI;
    if (z > Q24_PI) z = z - Q24_TWO_PI;
    else if (z < -Q24_PI) z = z + Q24_TWO_PI;
    if (z > Q24_HALF_PI) begin
      z = z - Q24_PI;
      flip = 1'b1;
    end else if (z < -Q24_HALF_PI) begin
      z = z + Q24_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(atan_q24(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(atan_q24(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // tangent of half the window, q.16, clamped to [0, max]
  function automatic longint half_tan(input logic [WW-1:0] win);
    longint s, c, q;
    cordic_sin_cos(longint'(win) * 1024, s, c);
    if (c <= 0) return CMAX;
    q = (s * 65536 + c / 2) / c;
    if (q < 0) return 0;
    if (q > CMAX) return CMAX;
    return q;
  endfunction

  function automatic longint prod_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // q2.30 entry times nonnegative q.16 coordinate, q.22 term
  function automatic longint coord_term(input longint e, input longint v);
    longint vh, vl;
    vh = v >>> 24;
    vl = v & 64'hFFFFFF;
    return e * vh + ((e * vl) >>> 24);
  endfunction

  function automatic logic signed [OW-1:0] rotate_row(input longint ex, input longint ey,
                                                      input longint ez, input longint x,
                                                      input longint y);
    longint sum;
    sum = coord_term(ex, x) + coord_term(ey, y) + coord_term(ez, 65536);
    sum = (sum + 32) >>> 6;
    if (sum > CMAX) sum = CMAX;
    if (sum < CMIN) sum = CMIN;
    return OW'(sum);
  endfunction

  // rotated origin, left-top and right-bottom corners
  function automatic corners_t rotate_corners(input view_t v);
    corners_t r;
    longint hx, hy, st, ct, sp, cp;
    longint m00, m01, m02, m11, m12, m20, m21, m22;
    hx = half_tan(v.win_h);
    hy = half_tan(v.win_v);
    cordic_sin_cos(longint'(v.tilt) * 2048, st, ct);
    cordic_sin_cos(longint'(v.pan) * 2048, sp, cp);
    m00 = cp;  m01 = prod_q30(sp, st); m02 = prod_q30(sp, ct);
    m11 = ct;  m12 = -st;
    m20 = -sp; m21 = prod_q30(cp, st); m22 = prod_q30(cp, ct);
    r.c[0] = rotate_row(-m00, -m01, m02, hx, hy);
    r.c[1] = rotate_row(0, -m11, m12, hx, hy);
    r.c[2] = rotate_row(-m20, -m21, m22, hx, hy);
    r.c[3] = rotate_row(-m00, m01, m02, hx, hy);
    r.c[4] = rotate_row(0, m11, m12, hx, hy);
    r.c[5] = rotate_row(-m20, m21, m22, hx, hy);
    r.c[6] = rotate_row(m00, -m01, m02, hx, hy);
    r.c[7] = rotate_row(0, -m11, m12, hx, hy);
    r.c[8] = rotate_row(m20, -m21, m22, hx, hy);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [OW-1:0] got,
                                 input logic signed [OW-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // predict on each input transfer
  always @(posedge clk) begin
    view_t v;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      v.win_h = in_ch.window_horizontal;
      v.win_v = in_ch.window_vertical;
      v.tilt  = in_ch.tilt_angle;
      v.pan   = in_ch.pan_angle;
      pending_corners.push_back(rotate_corners(v));
    end
  end

  // check each output transfer against the oldest prediction
  always @(posedge clk) begin
    corners_t want;
    logic signed [OW-1:0] got [9];
    string names [9];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_fired = 1'b1;
      got = '{out_ch.origin_x, out_ch.origin_y, out_ch.origin_z,
              out_ch.left_top_x, out_ch.left_top_y, out_ch.left_top_z,
              out_ch.right_bottom_x, out_ch.right_bottom_y, out_ch.right_bottom_z};
      names = '{"origin_x", "origin_y", "origin_z", "left_top_x", "left_top_y",
                "left_top_z", "right_bottom_x", "right_bottom_y", "right_bottom_z"};
      if (pending_corners.size() == 0) begin
        $display("unexpected output transfer at %0t", $realtime);
        mismatches++;
      end else begin
        want = pending_corners.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want.c[k]) report_mismatch(names[k], got[k], want.c[k]);
      end
    end
  end

  // output back-pressure, random stall per transfer
  always @(negedge clk) begin
    if (out_fired) begin
      out_fired = 1'b0;
      ready_hold = burst ? 0 : $urandom_range(0, 7);
    end
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  // drive one item after a random gap and hold it until the transfer
  task automatic send_view(input view_t v);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.window_horizontal <= v.win_h;
    in_ch.window_vertical   <= v.win_v;
    in_ch.tilt_angle        <= v.tilt;
    in_ch.pan_angle         <= v.pan;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic signed [AW-1:0] pick_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return AW'($urandom);
    if (r == 1) return AW'($urandom_range(0, 1) ? 25736 : -25736);
    return AW'($urandom_range(0, 51472) - 25736);
  endfunction

  function automatic logic [WW-1:0] pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return WW'($urandom);
    if (r == 1) return WW'($urandom_range(0, 1) ? 25735 : 0);
    return WW'($urandom_range(0, 25735));
  endfunction

  initial begin
    view_row_t rows [$];
    view_t     v;
    corners_t  hand;
    in_ch.valid             = 1'b0;
    in_ch.window_horizontal = '0;
    in_ch.window_vertical   = '0;
    in_ch.tilt_angle        = '0;
    in_ch.pan_angle         = '0;
    out_ch.ready            = 1'b0;

    // directed rows: extremes, quadrant edges, saturation
    rows = '{
      '{'{15'd0, 15'd0, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{15'd25735, 15'd25735, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{15'd32767, 15'd32767, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{15'd32767, 15'd32767, -16'sd6434, 16'sd6434}, 1'b1, 24'sd8388607},
      '{'{15'd12868, 15'd8578, 16'sd25736, 16'sd0}, 1'b0, '0},
      '{'{15'd12868, 15'd8578, -16'sd25736, 16'sd0}, 1'b0, '0},
      '{'{15'd12868, 15'd8578, 16'sd0, 16'sd25736}, 1'b0, '0},
      '{'{15'd12868, 15'd8578, 16'sd0, -16'sd25736}, 1'b0, '0},
      '{'{15'd8578, 15'd12868, 16'sd12868, 16'sd12868}, 1'b0, '0},
      '{'{15'd8578, 15'd12868, -16'sd12868, -16'sd12868}, 1'b0, '0},
      '{'{15'd8578, 15'd12868, 16'sd12869, -16'sd12869}, 1'b0, '0},
      '{'{15'd1, 15'd1, 16'sd32767, 16'sd32767}, 1'b0, '0},
      '{'{15'd1, 15'd1, -16'sd32768, -16'sd32768}, 1'b0, '0},
      '{'{15'd25000, 15'd100, 16'sd1, -16'sd1}, 1'b0, '0},
      '{'{15'd100, 15'd25000, -16'sd1, 16'sd1}, 1'b0, '0},
      '{'{15'd16384, 15'd30000, 16'sd20000, -16'sd20000}, 1'b0, '0}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (rows[i]) begin
      if (rows[i].z_known) begin
        hand = rotate_corners(rows[i].v);
        if (hand.c[2] !== rows[i].z_value)
          report_mismatch("hand origin_z", hand.c[2], rows[i].z_value);
      end
      send_view(rows[i].v);
    end

    // random part, bursts of back-to-back transfers now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 3) == 0);
      v.win_h = pick_window();
      v.win_v = pick_window();
      v.tilt  = pick_angle();
      v.pan   = pick_angle();
      send_view(v);
    end
    in_ch.valid <= 1'b0;
    burst = 1'b1;

    // drain
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("viewport_corner_rotation_core verification clean");
    end else begin
      $display("viewport_corner_rotation_core verification failed");
    end
    $finish;
  end

endmodule
